### hw/rtl/mspid_pkg.sv
// Shared constants and types for the motor speed PID regulator.
`timescale 1ns / 1ps
`default_nettype none

package mspid_pkg;

    localparam int TARGET_W = 16;
    localparam int COUNT_W  = 32;
    localparam int TIME_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int POWER_W  = 8;
    localparam int LIMIT_W  = 7;
    localparam int SPD_W    = 21;
    localparam int ERR_W    = 22;
    localparam int DERR_W   = 23;
    localparam int SUM_W    = 48;
    localparam int ACC_W    = 24;
    localparam int Q_W      = 16;
    localparam int SCALE_W  = 20;
    localparam int PROD_W   = 52;
    localparam int INC_W    = 66;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_STEPS = SCALE_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int PID_STEPS = GAIN_W;

    localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd1000000;
    localparam logic [LIMIT_W-1:0] POWER_CAP   = 7'd100;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd6554;
    localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd655;
    localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd0;
    localparam logic [LIMIT_W-1:0] START_RESET = 7'd20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_START_POWER = 3'd3,
        CFG_POWER_LIMIT = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_STOP = 2'd1,
        ACT_SET  = 2'd2
    } action_t;

endpackage

`default_nettype wire

### hw/rtl/motor_speed_pid_regulator_unit.sv
// Motor speed PID regulator: serial speed measurement and incremental PID update.
// Ticks without a PID step go from idle straight to the output stage; ticks with a speed
// measurement first run 20 multiply steps, 52 divide steps, 3 x 16 PID steps and setup.
// Flow: one tick at a time; the next tick is taken once the current one has
// reached the output register. The bit-serial multiplier, divider and PID steps keep it busy.
// Reset: gains and limits to their defaults, motor stopped, all regulator state zero.
`timescale 1ns / 1ps
`default_nettype none

module motor_speed_pid_regulator_unit
    import mspid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,    // target_speed, encoder_count, time_us
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // power, measured_speed, zero fill
    output logic [1:0]            m_tuser,    // action
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_ERR,
        ST_SUM,
        ST_LOAD,
        ST_PID,
        ST_CLAMP,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic [LIMIT_W-1:0] start_power_reg, power_limit_reg;

    logic                     running_reg;
    logic [COUNT_W-1:0]       prev_count_reg;
    logic [TIME_W-1:0]        prev_time_reg;
    logic signed [SPD_W-1:0]  speed_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [ERR_W-1:0]  last_error_reg;

    logic signed [TARGET_W-1:0] target_reg;
    logic                       neg_reg;
    logic [TIME_W-1:0]          elapsed_reg;
    logic [PROD_W-1:0]          work_reg;
    logic [PROD_W-1:0]          mcand_reg;
    logic [SCALE_W-1:0]         mplier_reg;
    logic [TIME_W-1:0]          rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [INC_W-1:0]    inc_reg;
    logic signed [INC_W-1:0]    op_reg;
    logic [GAIN_W-1:0]          gain_sh_reg;
    logic [1:0]                 term_reg;
    action_t                    res_action_reg;

    logic                       m_tvalid_reg;
    action_t                    out_action_reg;
    logic signed [POWER_W-1:0]  out_power_reg;
    logic signed [SPD_W-1:0]    out_speed_reg;

    logic signed [TARGET_W-1:0] in_target;
    logic [COUNT_W-1:0]         in_count;
    logic [TIME_W-1:0]          in_time;
    logic [COUNT_W-1:0]         cnt_diff;
    logic [COUNT_W-1:0]         cnt_mag;
    logic [TIME_W-1:0]          elapsed;
    logic [LIMIT_W-1:0]         sp_cap;
    logic [LIMIT_W-1:0]         lim_cap;
    logic signed [ACC_W-1:0]    sp_q16;
    logic signed [ACC_W-1:0]    start_acc;

    logic [PROD_W-1:0]          mul_sum;
    logic [TIME_W:0]            div_trial;
    logic                       div_ge;
    logic [TIME_W:0]            div_rem;
    logic [SCALE_W-1:0]         q_sat;
    logic [SPD_W-1:0]           q_mag;
    logic signed [SPD_W-1:0]    speed_next;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    error_sum_next;
    logic signed [DERR_W-1:0]   derr;
    logic signed [INC_W-1:0]    lim_wide;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [POWER_W-1:0]  acc_power;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_action_reg;
    assign m_tdata   = {3'b000, out_speed_reg, out_power_reg};

    assign in_target = signed'(s_tdata[15:0]);
    assign in_count  = s_tdata[47:16];
    assign in_time   = s_tdata[79:48];
    assign cnt_diff  = in_count - prev_count_reg;
    assign cnt_mag   = cnt_diff[COUNT_W-1] ? (~cnt_diff + 32'd1) : cnt_diff;
    assign elapsed   = in_time - prev_time_reg;

    assign sp_cap    = (start_power_reg > POWER_CAP) ? POWER_CAP : start_power_reg;
    assign lim_cap   = (power_limit_reg > POWER_CAP) ? POWER_CAP : power_limit_reg;
    assign sp_q16    = signed'({1'b0, sp_cap, {Q_W{1'b0}}});
    assign start_acc = in_target[TARGET_W-1] ? -sp_q16 : sp_q16;

    // serial multiply by the speed scale, restoring divide by elapsed time
    assign mul_sum   = work_reg + mcand_reg;
    assign div_trial = {rem_reg, work_reg[PROD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, elapsed_reg});
    assign div_rem   = div_trial - {1'b0, elapsed_reg};

    assign q_sat      = (work_reg > {{(PROD_W-SCALE_W){1'b0}}, SPEED_SCALE}) ? SPEED_SCALE
                                                                             : work_reg[SCALE_W-1:0];
    assign q_mag      = {1'b0, q_sat};
    assign speed_next = neg_reg ? signed'(21'd0 - q_mag) : signed'(q_mag);

    assign err_next = {{(ERR_W-TARGET_W){target_reg[TARGET_W-1]}}, target_reg}
                    - {speed_reg[SPD_W-1], speed_reg};

    assign sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                    + {{(SUM_W+1-ERR_W){err_reg[ERR_W-1]}}, err_reg};
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            error_sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            error_sum_next = sum_wide[SUM_W-1:0];
        end
    end

    assign derr = {err_reg[ERR_W-1], err_reg} - {last_error_reg[ERR_W-1], last_error_reg};

    assign lim_wide = signed'({{(INC_W-LIMIT_W-Q_W){1'b0}}, lim_cap, {Q_W{1'b0}}});
    always_comb
    begin
        if (inc_reg > lim_wide)
        begin
            acc_next = lim_wide[ACC_W-1:0];
        end
        else if (inc_reg < -lim_wide)
        begin
            acc_next = (-lim_wide[ACC_W-1:0]);
        end
        else
        begin
            acc_next = inc_reg[ACC_W-1:0];
        end
    end

    // truncate toward zero
    assign acc_power = acc_reg[ACC_W-1:Q_W]
                     + {{(POWER_W-1){1'b0}}, (acc_reg[ACC_W-1] && (acc_reg[Q_W-1:0] != '0))};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kp_reg          <= KP_RESET;
            ki_reg          <= KI_RESET;
            kd_reg          <= KD_RESET;
            start_power_reg <= START_RESET;
            power_limit_reg <= LIMIT_RESET;
            running_reg     <= 1'b0;
            prev_count_reg  <= '0;
            prev_time_reg   <= '0;
            speed_reg       <= '0;
            acc_reg         <= '0;
            error_sum_reg   <= '0;
            last_error_reg  <= '0;
            target_reg      <= '0;
            neg_reg         <= 1'b0;
            elapsed_reg     <= '0;
            work_reg        <= '0;
            mcand_reg       <= '0;
            mplier_reg      <= '0;
            rem_reg         <= '0;
            cnt_reg         <= '0;
            err_reg         <= '0;
            inc_reg         <= '0;
            op_reg          <= '0;
            gain_sh_reg     <= '0;
            term_reg        <= '0;
            res_action_reg  <= ACT_NONE;
            m_tvalid_reg    <= 1'b0;
            out_action_reg  <= ACT_NONE;
            out_power_reg   <= '0;
            out_speed_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:   kp_reg          <= cfg_data;
                    CFG_INTEG_GAIN:  ki_reg          <= cfg_data;
                    CFG_DERIV_GAIN:  kd_reg          <= cfg_data;
                    CFG_START_POWER: start_power_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_POWER_LIMIT: power_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:         ;
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        prev_count_reg <= in_count;
                        prev_time_reg  <= in_time;
                        target_reg     <= in_target;
                        if (in_target == '0)
                        begin
                            res_action_reg <= running_reg ? ACT_STOP : ACT_NONE;
                            running_reg    <= 1'b0;
                            state_reg      <= ST_DONE;
                        end
                        else if (!running_reg)
                        begin
                            acc_reg        <= start_acc;
                            running_reg    <= 1'b1;
                            res_action_reg <= ACT_SET;
                            state_reg      <= ST_DONE;
                        end
                        else if ((cnt_diff == '0) || (elapsed == '0))
                        begin
                            res_action_reg <= ACT_NONE;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            neg_reg     <= cnt_diff[COUNT_W-1];
                            mcand_reg   <= {{(PROD_W-COUNT_W){1'b0}}, cnt_mag};
                            mplier_reg  <= SPEED_SCALE;
                            work_reg    <= '0;
                            elapsed_reg <= elapsed;
                            cnt_reg     <= '0;
                            state_reg   <= ST_MUL;
                        end
                    end
                end

                ST_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        work_reg <= mul_sum;
                    end
                    mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[SCALE_W-1:1]};
                    if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                ST_DIV:
                begin
                    rem_reg  <= div_ge ? div_rem[TIME_W-1:0] : div_trial[TIME_W-1:0];
                    work_reg <= {work_reg[PROD_W-2:0], div_ge};
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SAT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                ST_SAT:
                begin
                    speed_reg <= speed_next;
                    state_reg <= ST_ERR;
                end

                ST_ERR:
                begin
                    err_reg   <= err_next;
                    state_reg <= ST_SUM;
                end

                ST_SUM:
                begin
                    error_sum_reg <= error_sum_next;
                    inc_reg       <= {{(INC_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
                    op_reg        <= {{(INC_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                    gain_sh_reg   <= kp_reg;
                    term_reg      <= 2'd0;
                    cnt_reg       <= '0;
                    state_reg     <= ST_PID;
                end

                ST_LOAD:
                begin
                    if (term_reg == 2'd1)
                    begin
                        op_reg      <= {{(INC_W-SUM_W){error_sum_reg[SUM_W-1]}}, error_sum_reg};
                        gain_sh_reg <= ki_reg;
                    end
                    else
                    begin
                        op_reg         <= {{(INC_W-DERR_W){derr[DERR_W-1]}}, derr};
                        gain_sh_reg    <= kd_reg;
                        last_error_reg <= err_reg;
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_PID;
                end

                ST_PID:
                begin
                    if (gain_sh_reg[0])
                    begin
                        inc_reg <= inc_reg + op_reg;
                    end
                    op_reg      <= {op_reg[INC_W-2:0], 1'b0};
                    gain_sh_reg <= {1'b0, gain_sh_reg[GAIN_W-1:1]};
                    if (cnt_reg == CNT_W'(PID_STEPS - 1))
                    begin
                        cnt_reg <= '0;
                        if (term_reg == 2'd2)
                        begin
                            state_reg <= ST_CLAMP;
                        end
                        else
                        begin
                            term_reg  <= term_reg + 2'd1;
                            state_reg <= ST_LOAD;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                ST_CLAMP:
                begin
                    acc_reg        <= acc_next;
                    res_action_reg <= ACT_SET;
                    state_reg      <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_action_reg <= res_action_reg;
                        out_power_reg  <= (res_action_reg == ACT_SET) ? acc_power : '0;
                        out_speed_reg  <= speed_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the motor speed PID regulator unit.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import mspid_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 160;
    localparam longint ONE_Q16 = 65536;
    localparam longint SPEED_MAX = 1000000;
    localparam longint ERR_SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ERR_SUM_MIN = -ERR_SUM_MAX - 1;

    typedef struct {
        action_t                    action;
        logic signed [POWER_W-1:0]  power;
        logic signed [SPD_W-1:0]    speed;
    } tick_result_t;

    class pid_tick_scoreboard;
        longint kp, ki, kd, start_pow, pow_limit;
        bit running;
        logic [COUNT_W-1:0] prev_count;
        logic [TIME_W-1:0] prev_time;
        longint speed_now, acc_q16, err_sum, last_err;
        tick_result_t expected_results[$];
        int errors;

        function new();
            kp = longint'(KP_RESET);
            ki = longint'(KI_RESET);
            kd = longint'(KD_RESET);
            start_pow = longint'(START_RESET);
            pow_limit = longint'(LIMIT_RESET);
            running = 0;
            prev_count = '0;
            prev_time = '0;
            speed_now = 0;
            acc_q16 = 0;
            err_sum = 0;
            last_err = 0;
            errors = 0;
        endfunction

        function longint capped(longint v);
            return (v > 100) ? 100 : v;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PROP_GAIN:   kp = longint'(val);
                CFG_INTEG_GAIN:  ki = longint'(val);
                CFG_DERIV_GAIN:  kd = longint'(val);
                CFG_START_POWER: start_pow = longint'(val[LIMIT_W-1:0]);
                CFG_POWER_LIMIT: pow_limit = longint'(val[LIMIT_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_tick(logic signed [TARGET_W-1:0] tgt, logic [COUNT_W-1:0] cnt,
                                logic [TIME_W-1:0] tm);
            tick_result_t res;
            logic [COUNT_W-1:0] dcnt;
            logic [TIME_W-1:0] elapsed;
            longint delta, spd, err, inc, lim;
            res.action = ACT_NONE;
            res.power = '0;
            if (tgt == 0) begin
                if (running) begin
                    running = 0;
                    res.action = ACT_STOP;
                end
            end else if (!running) begin
                lim = capped(start_pow) * ONE_Q16;
                acc_q16 = (tgt < 0) ? -lim : lim;
                running = 1;
                res.action = ACT_SET;
                res.power = POWER_W'(acc_q16 / ONE_Q16);
            end else if (cnt != prev_count) begin
                dcnt = cnt - prev_count;
                elapsed = tm - prev_time;
                if (elapsed != 0) begin
                    delta = longint'($signed(dcnt));
                    spd = (delta * 1000000) / longint'({32'd0, elapsed});
                    if (spd > SPEED_MAX) spd = SPEED_MAX;
                    if (spd < -SPEED_MAX) spd = -SPEED_MAX;
                    speed_now = spd;
                    err = longint'(tgt) - spd;
                    err_sum = err_sum + err;
                    if (err_sum > ERR_SUM_MAX) err_sum = ERR_SUM_MAX;
                    if (err_sum < ERR_SUM_MIN) err_sum = ERR_SUM_MIN;
                    inc = kp * err + ki * err_sum + kd * (err - last_err);
                    last_err = err;
                    lim = capped(pow_limit) * ONE_Q16;
                    acc_q16 = acc_q16 + inc;
                    if (acc_q16 > lim) acc_q16 = lim;
                    if (acc_q16 < -lim) acc_q16 = -lim;
                    res.action = ACT_SET;
                    res.power = POWER_W'(acc_q16 / ONE_Q16);
                end
            end
            prev_count = cnt;
            prev_time = tm;
            res.speed = SPD_W'(speed_now);
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] act, logic [POWER_W-1:0] pwr,
                                   logic [SPD_W-1:0] spd, logic [2:0] fill);
            tick_result_t exp_res;
            if (expected_results.size() == 0) begin
                $error("result transfer with no pending tick");
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (act !== exp_res.action) begin
                $error("action: expected %0d, got %0d", exp_res.action, act);
                errors++;
            end
            if (pwr !== exp_res.power) begin
                $error("power: expected %0d, got %0d", exp_res.power, $signed(pwr));
                errors++;
            end
            if (spd !== exp_res.speed) begin
                $error("measured_speed: expected %0d, got %0d", exp_res.speed, $signed(spd));
                errors++;
            end
            if (fill !== 3'b000) begin
                $error("zero_fill: expected 0, got %0d", fill);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [79:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int cycle_count = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit calm = 1'b0;
    int rx_stall_left = 0;
    logic [COUNT_W-1:0] motor_count = '0;
    logic [TIME_W-1:0] clock_us = '0;

    pid_tick_scoreboard sb = new();

    motor_speed_pid_regulator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // receiver: random stall bursts, started only while rx_idle is set and calm is clear
    always @(posedge clk)
    begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_idle && !calm && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[7:0], m_tdata[28:8], m_tdata[31:29]);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_tick(input logic signed [TARGET_W-1:0] tgt,
                             input logic [COUNT_W-1:0] cnt, input logic [TIME_W-1:0] tm);
        if (tx_idle && !calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {tm, cnt, tgt};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_tick(tgt, cnt, tm);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [15:0] start_pow,
                              input logic [15:0] lim);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_START_POWER, start_pow);
        write_reg(CFG_POWER_LIMIT, lim);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_ticks(input int n, input int pause_at);
        int unsigned pick;
        logic signed [TARGET_W-1:0] tgt;
        for (int i = 0; i < n; i++) begin
            if (i % 48 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (i == pause_at)
                drain();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise: fully random fields
                motor_count = $urandom;
                clock_us = $urandom;
                send_tick(TARGET_W'($urandom), motor_count, clock_us);
            end else begin
                if (pick < 13) begin
                    tgt = '0;
                end else if ($urandom_range(0, 9) == 0) begin
                    tgt = TARGET_W'($urandom);
                end else begin
                    tgt = TARGET_W'($urandom_range(0, 4000) - 2000);
                end
                if (pick >= 13 && tgt == 0)
                    tgt = 16'sd1;
                pick = $urandom_range(0, 19);
                if (pick == 1)
                    motor_count = motor_count + $urandom;
                else if (pick != 0)
                    motor_count = motor_count + $urandom_range(0, 400) - 200;
                pick = $urandom_range(0, 19);
                if (pick == 1)
                    clock_us = clock_us + $urandom;
                else if (pick == 2 || pick == 3)
                    clock_us = clock_us + $urandom_range(1, 8);
                else if (pick != 0)
                    clock_us = clock_us + $urandom_range(100, 200000);
                send_tick(tgt, motor_count, clock_us);
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset gains
        send_tick(16'sd0, 32'd0, 32'd0);
        send_tick(16'sd32767, 32'd0, 32'd1000);
        send_tick(16'sd32767, 32'd0, 32'd2000);
        send_tick(16'sd32767, 32'd100, 32'd2000);
        send_tick(16'sd32767, 32'd200, 32'd12000);
        send_tick(16'sd32767, 32'h7FFF_FFFF, 32'd12001);
        send_tick(16'sd32767, 32'h8000_0000, 32'd12002);
        send_tick(-16'sd32768, 32'h7FFF_FF00, 32'd12003);
        send_tick(-16'sd32768, 32'h7FFF_FE00, 32'hFFFF_FFF0);
        send_tick(-16'sd1, 32'h7FFF_FE10, 32'h0000_0010);
        send_tick(16'sd0, 32'h7FFF_FE20, 32'h0000_0020);
        send_tick(16'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(-16'sd32768, 32'h0000_0000, 32'h0000_0000);
        send_tick(16'sd1, 32'h0000_0005, 32'h0000_0064);
        send_tick(16'sd0, 32'h0000_0006, 32'h0000_00C8);
        send_tick(16'sd1, 32'h8000_0000, 32'h8000_0000);
        send_tick(16'sd1, 32'h0000_0000, 32'h0000_0001);
        send_tick(16'sd0, 32'h0000_0000, 32'h0000_0001);
        drain();
        run_ticks(290, -1);

        load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127, 16'd127);
        run_ticks(290, -1);

        load_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_ticks(290, -1);

        load_gains(16'($urandom), 16'($urandom_range(0, 2000)), 16'($urandom),
                   16'd100, 16'd1);
        run_ticks(290, 150);

        load_gains(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 127)), 16'($urandom_range(0, 127)));
        run_ticks(290, -1);

        load_gains(16'd6554, 16'd655, 16'd3000, 16'd20, 16'd100);
        calm = 1'b1;
        run_ticks(290, -1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
